// ===== sv/scgc_pkg.sv =====
`timescale 1ns / 1ps

package scgc_pkg;

   // request codes
   typedef logic [1:0] func_type;

   localparam func_type FUNC_READ  = 2'd0;
   localparam func_type FUNC_WRITE = 2'd1;
   localparam func_type FUNC_FLUSH = 2'd2;

   // per-slot use count
   localparam int CNT_W = 3;

   localparam logic [CNT_W-1:0] USE_LIMIT_RESET = 3'd5;

endpackage

// ===== sv/sector_cache_gclock_policy_top.sv =====
`timescale 1ns / 1ps

// GCLOCK replacement metadata engine for a fully associative sector cache.
//
// req_*: one beat per command (read, write or flush) with a sector number;
//   req_stall is high while a command is in progress, one command at a time.
// rsp_*: read and write give one beat (slot, hit, writeback info); a flush
//   gives one beat per dirty slot in slot order, or one empty beat if none
//   is dirty. rsp_last marks the final beat of a command.
// csr_*: use_limit, the use-count ceiling; write only while idle.
//
// The slot RAM is read one slot per cycle during the tag search and the
// clock sweep. A miss scans all NUM_SLOTS slots, then sweeps from the clock
// hand, aging each valid slot with a nonzero use count, up to the first
// invalid or zero-count slot. A flush skips clean slots. The engine goes
// idle as the final beat is loaded into the output register, so the next
// command can be taken even while that beat is still stalled.
//
// Reset clears the valid, dirty and hand state at once; there is no clear
// pass. A stalled rsp beat holds; the engine waits before loading another.
module sector_cache_gclock_policy_top
   import scgc_pkg::*;
#(
   parameter int NUM_SLOTS   = 64,
   parameter int NUM_SECTORS = 16384
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic [$clog2(NUM_SECTORS)-1:0] req_sector,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [$clog2(NUM_SLOTS)-1:0]   rsp_slot_index,
   output logic                           rsp_hit,
   output logic                           rsp_writeback,
   output logic [$clog2(NUM_SECTORS)-1:0] rsp_writeback_sector,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [CNT_W-1:0]               csr_wr_data
);

   localparam int SLOT_W   = $clog2(NUM_SLOTS);
   localparam int SECTOR_W = $clog2(NUM_SECTORS);
   localparam int ENTRY_W  = SECTOR_W + CNT_W;

   logic [CNT_W-1:0]    use_limit_ff;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_hit_ff;
   logic                rsp_wb_ff;
   logic [SECTOR_W-1:0] rsp_wbs_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                seq_emit;
   logic [SLOT_W-1:0]   res_slot;
   logic                res_hit;
   logic                res_wb;
   logic [SECTOR_W-1:0] res_wbs;
   logic                res_last;

   logic                mem_rd_en;
   logic [SLOT_W-1:0]   mem_rd_addr;
   logic [ENTRY_W-1:0]  mem_rd_data;
   logic                mem_wr_en;
   logic [SLOT_W-1:0]   mem_wr_addr;
   logic [ENTRY_W-1:0]  mem_wr_data;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         use_limit_ff <= USE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         use_limit_ff <= csr_wr_data;
      end
   end

   // output register: free when empty or being taken this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_emit) begin
         rsp_slot_ff <= res_slot;
         rsp_hit_ff  <= res_hit;
         rsp_wb_ff   <= res_wb;
         rsp_wbs_ff  <= res_wbs;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot_index       = rsp_slot_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_writeback        = rsp_wb_ff;
   assign rsp_writeback_sector = rsp_wbs_ff;
   assign rsp_last             = rsp_last_ff;

   // slot RAM: {tag, use count} per slot
   scgc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   scgc_seq #(
      .NUM_SLOTS   (NUM_SLOTS),
      .NUM_SECTORS (NUM_SECTORS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_sector  (req_sector),
      .use_limit   (use_limit_ff),
      .out_free    (out_free),
      .emit        (seq_emit),
      .res_slot    (res_slot),
      .res_hit     (res_hit),
      .res_wb      (res_wb),
      .res_wbs     (res_wbs),
      .res_last    (res_last),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // a real command always makes the engine busy next cycle
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_func == FUNC_READ || req_func == FUNC_WRITE || req_func == FUNC_FLUSH))
      |=> req_stall)
      else $error("command accepted but engine not busy");

   // never overwrite a beat still held by the receiver
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      seq_emit |-> out_free)
      else $error("result loaded over a stalled beat");

   // results only come from a command in progress
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      seq_emit |-> req_stall)
      else $error("result emitted while idle");

endmodule

// ===== sv/scgc_ram.sv =====
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module scgc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/scgc_seq.sv =====
`timescale 1ns / 1ps

// slot walker: tag search, clock sweep and flush over the slot RAM
module scgc_seq
   import scgc_pkg::*;
#(
   parameter int NUM_SLOTS   = 64,
   parameter int NUM_SECTORS = 16384
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_func,
   input  logic [$clog2(NUM_SECTORS)-1:0]      req_sector,
   input  logic [CNT_W-1:0]                    use_limit,
   input  logic                                out_free,
   output logic                                emit,
   output logic [$clog2(NUM_SLOTS)-1:0]        res_slot,
   output logic                                res_hit,
   output logic                                res_wb,
   output logic [$clog2(NUM_SECTORS)-1:0]      res_wbs,
   output logic                                res_last,
   output logic                                mem_rd_en,
   output logic [$clog2(NUM_SLOTS)-1:0]        mem_rd_addr,
   input  logic [$clog2(NUM_SECTORS)+CNT_W-1:0] mem_rd_data,
   output logic                                mem_wr_en,
   output logic [$clog2(NUM_SLOTS)-1:0]        mem_wr_addr,
   output logic [$clog2(NUM_SECTORS)+CNT_W-1:0] mem_wr_data
);

   localparam int SLOT_W   = $clog2(NUM_SLOTS);
   localparam int SECTOR_W = $clog2(NUM_SECTORS);
   localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SECTOR_W:0]   NSEC      = (SECTOR_W + 1)'(NUM_SECTORS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_FLUSH,
      ST_FL_TAG,
      ST_EMIT
   } state_type;

   function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
   endfunction

   state_type             state_ff, state_in;
   logic [1:0]            func_ff, func_in;
   logic [SECTOR_W-1:0]   sector_ff, sector_in;
   logic [SLOT_W-1:0]     ptr_ff, ptr_in;
   logic [SLOT_W-1:0]     cmp_ff, cmp_in;
   logic [SLOT_W-1:0]     hand_ff, hand_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]  dirty_ff, dirty_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_wb_ff, res_wb_in;
   logic [SECTOR_W-1:0]   res_wbs_ff, res_wbs_in;
   logic                  res_last_ff, res_last_in;

   logic [SECTOR_W-1:0]   rd_tag;
   logic [CNT_W-1:0]      rd_cnt;
   logic [CNT_W-1:0]      cnt_eff;
   logic [SECTOR_W:0]     sec_ext;
   logic [SECTOR_W-1:0]   sector_mod;
   logic                  more_dirty;
   logic                  victim_wb;

   assign rd_tag  = mem_rd_data[SECTOR_W+CNT_W-1:CNT_W];
   assign rd_cnt  = mem_rd_data[CNT_W-1:0];
   assign cnt_eff = valid_ff[cmp_ff] ? rd_cnt : '0;
   assign victim_wb = valid_ff[cmp_ff] & dirty_ff[cmp_ff];

   // sector fold: the port is just wide enough, so one subtract does it
   assign sec_ext    = {1'b0, req_sector};
   assign sector_mod = (sec_ext >= NSEC) ? SECTOR_W'(sec_ext - NSEC) : req_sector;

   // any dirty slot above the flush pointer
   always_comb begin
      more_dirty = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         more_dirty = more_dirty | (dirty_ff[i] & (SLOT_W'(i) > ptr_ff));
      end
   end

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      sector_in   = sector_ff;
      ptr_in      = ptr_ff;
      cmp_in      = cmp_ff;
      hand_in     = hand_ff;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      res_slot_in = res_slot_ff;
      res_hit_in  = res_hit_ff;
      res_wb_in   = res_wb_ff;
      res_wbs_in  = res_wbs_ff;
      res_last_in = res_last_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cmp_ff;
      mem_wr_data = {rd_tag, rd_cnt};
      emit        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               sector_in = sector_mod;
               unique case (req_func) inside
                  FUNC_FLUSH: begin
                     ptr_in   = '0;
                     state_in = ST_FLUSH;
                  end
                  FUNC_READ, FUNC_WRITE: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     ptr_in      = SLOT_W'(1);
                     cmp_in      = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // one read issued per cycle, compare runs one slot behind
            mem_rd_en = 1'b1;
            ptr_in    = inc_slot(ptr_ff);
            cmp_in    = ptr_ff;
            if (valid_ff[cmp_ff] && (rd_tag == sector_ff)) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {rd_tag, (rd_cnt < use_limit) ? rd_cnt + CNT_W'(1) : rd_cnt};
               if (func_ff == FUNC_WRITE) begin
                  dirty_in[cmp_ff] = 1'b1;
               end
               res_slot_in = cmp_ff;
               res_hit_in  = 1'b1;
               res_wb_in   = 1'b0;
               res_wbs_in  = '0;
               res_last_in = 1'b1;
               state_in    = ST_EMIT;
            end else if (cmp_ff == LAST_SLOT) begin
               mem_rd_addr = hand_ff;
               ptr_in      = inc_slot(hand_ff);
               cmp_in      = hand_ff;
               state_in    = ST_SWEEP;
            end
         end

         ST_SWEEP: begin
            if (cnt_eff != '0) begin
               // second chance: age the slot and move on
               mem_wr_en   = 1'b1;
               mem_wr_data = {rd_tag, rd_cnt - CNT_W'(1)};
               mem_rd_en   = 1'b1;
               ptr_in      = inc_slot(ptr_ff);
               cmp_in      = ptr_ff;
            end else begin
               mem_wr_en        = 1'b1;
               mem_wr_data      = {sector_ff, (use_limit != '0) ? CNT_W'(1) : CNT_W'(0)};
               valid_in[cmp_ff] = 1'b1;
               dirty_in[cmp_ff] = (func_ff == FUNC_WRITE);
               hand_in          = inc_slot(cmp_ff);
               res_slot_in      = cmp_ff;
               res_hit_in       = 1'b0;
               res_wb_in        = victim_wb;
               res_wbs_in       = victim_wb ? rd_tag : '0;
               res_last_in      = 1'b1;
               state_in         = ST_EMIT;
            end
         end

         ST_FLUSH: begin
            if (dirty_ff[ptr_ff]) begin
               mem_rd_en = 1'b1;
               state_in  = ST_FL_TAG;
            end else if (ptr_ff == LAST_SLOT) begin
               // nothing dirty at all: single empty beat
               res_slot_in = '0;
               res_hit_in  = 1'b0;
               res_wb_in   = 1'b0;
               res_wbs_in  = '0;
               res_last_in = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               ptr_in = inc_slot(ptr_ff);
            end
         end

         ST_FL_TAG: begin
            dirty_in[ptr_ff] = 1'b0;
            res_slot_in      = ptr_ff;
            res_hit_in       = 1'b0;
            res_wb_in        = 1'b1;
            res_wbs_in       = rd_tag;
            res_last_in      = ~more_dirty;
            state_in         = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if ((func_ff == FUNC_FLUSH) && !res_last_ff) begin
                  ptr_in   = inc_slot(ptr_ff);
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hand_ff  <= '0;
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         state_ff <= state_in;
         hand_ff  <= hand_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
      end
      func_ff     <= func_in;
      sector_ff   <= sector_in;
      ptr_ff      <= ptr_in;
      cmp_ff      <= cmp_in;
      res_slot_ff <= res_slot_in;
      res_hit_ff  <= res_hit_in;
      res_wb_ff   <= res_wb_in;
      res_wbs_ff  <= res_wbs_in;
      res_last_ff <= res_last_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_slot  = res_slot_ff;
   assign res_hit   = res_hit_ff;
   assign res_wb    = res_wb_ff;
   assign res_wbs   = res_wbs_ff;
   assign res_last  = res_last_ff;

endmodule
